// File: rtl/nbd_pkg.sv
package nbd_pkg;

    localparam int PIXEL_W       = 8;
    localparam int PIXEL_MAX     = 255;
    localparam int VALUE_W       = 16;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 9;
    localparam int SCALE_CFG_W   = 5;
    localparam int DIM_CFG_W     = 9;
    localparam int HEIGHT_LIMIT  = 256;
    localparam int ROW_W         = 9;
    localparam int MAX_WIDTH_DEF = 256;
    localparam int MAX_SCALE_DEF = 16;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 2'd2;

    localparam int SCALE_RST  = 1;
    localparam int WIDTH_RST  = 28;
    localparam int HEIGHT_RST = 28;

    localparam logic [VALUE_W-1:0] VALUE_OFFSET = 16'h8000;

    // per-pixel control from the position sequencer
    typedef struct packed {
        logic valid;
        logic in_area;
        logic first;
        logic emit;
        logic last;
    } pix_ctl_t;

    // per-result control down the divide pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } res_ctl_t;

    function automatic int sum_width(input int max_scale);
        return $clog2(PIXEL_MAX * max_scale * max_scale + 1);
    endfunction

endpackage

// File: rtl/nbd_seq.sv
module nbd_seq #(
    parameter int MaxWidth = nbd_pkg::MAX_WIDTH_DEF,
    parameter int MaxScale = nbd_pkg::MAX_SCALE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [nbd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [nbd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                accept,
    input  logic                                adv,
    input  logic [nbd_pkg::PIXEL_W-1:0]         pixel_in,
    output logic [$clog2(MaxScale+1)-1:0]       scale_o,
    output logic [$clog2(MaxWidth)-1:0]         rd_addr,
    output nbd_pkg::pix_ctl_t                   op_o,
    output logic [$clog2(MaxWidth)-1:0]         op_addr_o,
    output logic [nbd_pkg::PIXEL_W-1:0]         op_pixel_o
);

    localparam int ScaleW   = $clog2(MaxScale + 1);
    localparam int SubW     = $clog2(MaxScale);
    localparam int WidthW   = $clog2(MaxWidth + 1);
    localparam int AddrW    = $clog2(MaxWidth);
    localparam int ColBaseW = $clog2(MaxWidth + 2 * MaxScale + 1);
    localparam int RowBaseW = $clog2(nbd_pkg::HEIGHT_LIMIT + 2 * MaxScale + 1);
    localparam int RowW     = nbd_pkg::ROW_W;

    logic [ScaleW-1:0]   scale_reg, scale_next;
    logic [WidthW-1:0]   width_reg, width_next;
    logic [RowW-1:0]     height_reg, height_next;
    logic [WidthW-1:0]   pcol_reg, pcol_next;
    logic [RowW-1:0]     prow_reg, prow_next;
    logic [SubW-1:0]     sub_col_reg, sub_col_next;
    logic [SubW-1:0]     sub_row_reg, sub_row_next;
    logic [AddrW-1:0]    out_col_reg, out_col_next;
    logic [ColBaseW-1:0] col_base_reg, col_base_next;
    logic [RowBaseW-1:0] row_base_reg, row_base_next;
    nbd_pkg::pix_ctl_t   op_reg, op_next;
    logic [AddrW-1:0]    op_addr_reg, op_addr_next;
    logic [nbd_pkg::PIXEL_W-1:0] op_pixel_reg, op_pixel_next;

    logic [SubW-1:0]     scale_m1;
    logic [ColBaseW-1:0] scale_cb;
    logic [RowBaseW-1:0] scale_rb;
    logic                col_fit, row_fit, col_last, row_last;
    logic                first_c, blk_end_c, in_area_c;
    logic [WidthW-1:0]   pcol_inc;
    logic [RowW-1:0]     prow_inc;
    logic [nbd_pkg::CFG_DATA_W-1:0] cfg_val;

    assign scale_m1 = SubW'(scale_reg - ScaleW'(1));
    assign scale_cb = ColBaseW'(scale_reg);
    assign scale_rb = RowBaseW'(scale_reg);

    // a block column or band is used only if the whole block fits
    assign col_fit  = (col_base_reg + scale_cb) <= ColBaseW'(width_reg);
    assign row_fit  = (row_base_reg + scale_rb) <= RowBaseW'(height_reg);
    assign col_last = (col_base_reg + scale_cb + scale_cb) > ColBaseW'(width_reg);
    assign row_last = (row_base_reg + scale_rb + scale_rb) > RowBaseW'(height_reg);

    assign in_area_c = col_fit && row_fit;
    assign first_c   = (sub_row_reg == '0) && (sub_col_reg == '0);
    assign blk_end_c = (sub_row_reg == scale_m1) && (sub_col_reg == scale_m1);
    assign pcol_inc  = WidthW'(pcol_reg + WidthW'(1));
    assign prow_inc  = RowW'(prow_reg + RowW'(1));
    assign cfg_val   = cfg_wdata;

    always_comb begin
        scale_next    = scale_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        pcol_next     = pcol_reg;
        prow_next     = prow_reg;
        sub_col_next  = sub_col_reg;
        sub_row_next  = sub_row_reg;
        out_col_next  = out_col_reg;
        col_base_next = col_base_reg;
        row_base_next = row_base_reg;
        op_next       = op_reg;
        op_addr_next  = op_addr_reg;
        op_pixel_next = op_pixel_reg;

        if (adv) begin
            op_next = '0;
        end

        if (cfg_we) begin
            case (cfg_addr)
                nbd_pkg::CFG_SCALE: begin
                    if (cfg_val[nbd_pkg::SCALE_CFG_W-1:0] == '0) begin
                        scale_next = ScaleW'(1);
                    end else if (32'(cfg_val[nbd_pkg::SCALE_CFG_W-1:0]) > 32'(MaxScale)) begin
                        scale_next = ScaleW'(MaxScale);
                    end else begin
                        scale_next = ScaleW'(cfg_val[nbd_pkg::SCALE_CFG_W-1:0]);
                    end
                end
                nbd_pkg::CFG_WIDTH: begin
                    if (cfg_val[nbd_pkg::DIM_CFG_W-1:0] == '0) begin
                        width_next = WidthW'(1);
                    end else if (32'(cfg_val[nbd_pkg::DIM_CFG_W-1:0]) > 32'(MaxWidth)) begin
                        width_next = WidthW'(MaxWidth);
                    end else begin
                        width_next = WidthW'(cfg_val[nbd_pkg::DIM_CFG_W-1:0]);
                    end
                end
                nbd_pkg::CFG_HEIGHT: begin
                    if (cfg_val[nbd_pkg::DIM_CFG_W-1:0] == '0) begin
                        height_next = RowW'(1);
                    end else if (32'(cfg_val[nbd_pkg::DIM_CFG_W-1:0]) >
                                 32'(nbd_pkg::HEIGHT_LIMIT)) begin
                        height_next = RowW'(nbd_pkg::HEIGHT_LIMIT);
                    end else begin
                        height_next = RowW'(cfg_val[nbd_pkg::DIM_CFG_W-1:0]);
                    end
                end
                default: ;
            endcase
            if (cfg_addr == nbd_pkg::CFG_SCALE || cfg_addr == nbd_pkg::CFG_WIDTH ||
                cfg_addr == nbd_pkg::CFG_HEIGHT) begin
                pcol_next     = '0;
                prow_next     = '0;
                sub_col_next  = '0;
                sub_row_next  = '0;
                out_col_next  = '0;
                col_base_next = '0;
                row_base_next = '0;
            end
        end else if (accept) begin
            op_next.valid   = 1'b1;
            op_next.in_area = in_area_c;
            op_next.first   = first_c;
            op_next.emit    = in_area_c && blk_end_c;
            op_next.last    = col_last && row_last;
            op_addr_next    = out_col_reg;
            op_pixel_next   = pixel_in;

            if (in_area_c) begin
                if (sub_col_reg == scale_m1) begin
                    sub_col_next  = '0;
                    out_col_next  = AddrW'(out_col_reg + AddrW'(1));
                    col_base_next = ColBaseW'(col_base_reg + scale_cb);
                end else begin
                    sub_col_next  = SubW'(sub_col_reg + SubW'(1));
                end
            end

            if (pcol_inc >= width_reg) begin
                pcol_next     = '0;
                sub_col_next  = '0;
                out_col_next  = '0;
                col_base_next = '0;
                prow_next     = prow_inc;
                if (sub_row_reg >= scale_m1) begin
                    sub_row_next  = '0;
                    row_base_next = RowBaseW'(row_base_reg + scale_rb);
                end else begin
                    sub_row_next  = SubW'(sub_row_reg + SubW'(1));
                end
                // end of image
                if (prow_inc >= height_reg) begin
                    prow_next     = '0;
                    sub_row_next  = '0;
                    row_base_next = '0;
                end
            end else begin
                pcol_next = pcol_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg    <= ScaleW'(nbd_pkg::SCALE_RST);
            width_reg    <= WidthW'(nbd_pkg::WIDTH_RST);
            height_reg   <= RowW'(nbd_pkg::HEIGHT_RST);
            pcol_reg     <= '0;
            prow_reg     <= '0;
            sub_col_reg  <= '0;
            sub_row_reg  <= '0;
            out_col_reg  <= '0;
            col_base_reg <= '0;
            row_base_reg <= '0;
            op_reg       <= '0;
        end else begin
            scale_reg    <= scale_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            pcol_reg     <= pcol_next;
            prow_reg     <= prow_next;
            sub_col_reg  <= sub_col_next;
            sub_row_reg  <= sub_row_next;
            out_col_reg  <= out_col_next;
            col_base_reg <= col_base_next;
            row_base_reg <= row_base_next;
            op_reg       <= op_next;
        end
        op_addr_reg  <= op_addr_next;
        op_pixel_reg <= op_pixel_next;
    end

    assign scale_o    = scale_reg;
    assign rd_addr    = out_col_reg;
    assign op_o       = op_reg;
    assign op_addr_o  = op_addr_reg;
    assign op_pixel_o = op_pixel_reg;

endmodule

// File: rtl/nbd_acc.sv
module nbd_acc #(
    parameter int MaxWidth = nbd_pkg::MAX_WIDTH_DEF,
    parameter int MaxScale = nbd_pkg::MAX_SCALE_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      adv,
    input  logic                                      rd_en,
    input  logic [$clog2(MaxWidth)-1:0]               rd_addr,
    input  nbd_pkg::pix_ctl_t                         op_i,
    input  logic [$clog2(MaxWidth)-1:0]               op_addr_i,
    input  logic [nbd_pkg::PIXEL_W-1:0]               op_pixel_i,
    output logic [nbd_pkg::sum_width(MaxScale)-1:0]   sum_o,
    output nbd_pkg::res_ctl_t                         ctl_o
);

    localparam int SumW  = nbd_pkg::sum_width(MaxScale);
    localparam int AddrW = $clog2(MaxWidth);

    // one partial block sum per block column
    logic [SumW-1:0] col_mem [MaxWidth];

    logic [SumW-1:0]   rd_data_reg;
    logic              fwd_reg, fwd_next;
    logic [SumW-1:0]   fwd_data_reg;
    logic [SumW-1:0]   sum_reg;
    nbd_pkg::res_ctl_t ctl_reg, ctl_next;

    logic              wr_en;
    logic [SumW-1:0]   base_c;
    logic [SumW-1:0]   sum_c;

    assign wr_en  = op_i.valid && op_i.in_area && adv;
    // a write in the same cycle as the read is not seen by the read
    assign base_c = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign sum_c  = op_i.first ? SumW'(op_pixel_i) : SumW'(base_c + SumW'(op_pixel_i));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            col_mem[op_addr_i] <= sum_c;
        end
        if (rd_en) begin
            rd_data_reg <= col_mem[rd_addr];
        end
    end

    always_comb begin
        fwd_next = fwd_reg;
        ctl_next = ctl_reg;
        if (rd_en) begin
            fwd_next = wr_en && (op_addr_i == AddrW'(rd_addr));
        end
        if (adv) begin
            ctl_next.valid = op_i.valid && op_i.emit;
            ctl_next.last  = op_i.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
            ctl_reg <= '0;
        end else begin
            fwd_reg <= fwd_next;
            ctl_reg <= ctl_next;
        end
        if (rd_en) begin
            fwd_data_reg <= sum_c;
        end
        if (adv) begin
            sum_reg <= sum_c;
        end
    end

    assign sum_o = sum_reg;
    assign ctl_o = ctl_reg;

endmodule

// File: rtl/nbd_div.sv
module nbd_div #(
    parameter int MaxScale = nbd_pkg::MAX_SCALE_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     adv,
    input  logic [$clog2(MaxScale+1)-1:0]            scale_i,
    input  logic [nbd_pkg::sum_width(MaxScale)-1:0]  sum_i,
    input  nbd_pkg::res_ctl_t                        ctl_i,
    output logic [nbd_pkg::VALUE_W-1:0]              value_o,
    output nbd_pkg::res_ctl_t                        ctl_o
);

    localparam int ScaleW  = $clog2(MaxScale + 1);
    localparam int SumW    = nbd_pkg::sum_width(MaxScale);
    localparam int DivW    = $clog2(MaxScale * MaxScale);
    localparam int FracW   = 8;
    // exact floor(sum*256/d) for every d up to MaxScale^2
    localparam int RecipK  = SumW + FracW + DivW;
    localparam int RecipW  = RecipK + 1;
    localparam int LoW     = RecipW / 2;
    localparam int HiW     = RecipW - LoW;
    localparam int ProdW   = SumW + RecipW;
    localparam int ShiftQ  = RecipK - FracW;
    localparam int TabN    = 2 ** ScaleW;

    logic [RecipW-1:0] recip_tab [TabN];

    for (genvar g = 0; g < TabN; g++) begin : g_recip
        localparam longint unsigned Div = (g == 0 || g > MaxScale) ? 64'd1 : 64'(g * g);
        localparam longint unsigned Recip = ((64'd1 << RecipK) + Div - 64'd1) / Div;
        assign recip_tab[g] = RecipW'(Recip);
    end

    logic [RecipW-1:0]    recip_c;
    logic [SumW+LoW-1:0]  plo_reg;
    logic [SumW+HiW-1:0]  phi_reg;
    nbd_pkg::res_ctl_t    ctl_reg, ctl_next;
    logic [ProdW-1:0]     prod_c;
    logic [nbd_pkg::VALUE_W-1:0] quot_c;

    assign recip_c = recip_tab[scale_i];

    always_comb begin
        ctl_next = ctl_reg;
        if (adv) begin
            ctl_next = ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
        end
        if (adv) begin
            plo_reg <= (SumW+LoW)'(sum_i) * (SumW+LoW)'(recip_c[LoW-1:0]);
            phi_reg <= (SumW+HiW)'(sum_i) * (SumW+HiW)'(recip_c[RecipW-1:LoW]);
        end
    end

    assign prod_c  = ProdW'(plo_reg) + (ProdW'(phi_reg) << LoW);
    assign quot_c  = prod_c[ShiftQ +: nbd_pkg::VALUE_W];
    assign value_o = nbd_pkg::VALUE_W'(quot_c + nbd_pkg::VALUE_OFFSET);
    assign ctl_o   = ctl_reg;

endmodule

// File: rtl/normalized_box_downsampler.sv
// Block-average downsampler for 8-bit grey images in raster order. Each result is the mean of
// one scale x scale block as signed Q1.15, pixel/128 - 1 averaged, with m_tlast on the final
// block of the image; pixels of partial blocks at the right and bottom edges give no result.
// One pixel is taken per cycle while s_tready is high, and s_tready drops only while a result
// waits at the output with m_tready low. Partial sums per block column live in a one-port-
// read, one-port-write memory that is read when a pixel is taken and written back on the next
// cycle the pipeline moves; back-to-back pixels of the same block column take the fresh sum
// over a bypass, so the memory loop does not limit the rate. The divide by scale squared is a
// multiply by a constant reciprocal. Data passes the op, sum, product and output registers.
// A scale, width or height write restarts the current image; write only while idle.
module normalized_box_downsampler #(
    parameter int MaxWidth = nbd_pkg::MAX_WIDTH_DEF,
    parameter int MaxScale = nbd_pkg::MAX_SCALE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] pixel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [15:0] value
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [nbd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [nbd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int ScaleW = $clog2(MaxScale + 1);
    localparam int AddrW  = $clog2(MaxWidth);
    localparam int SumW   = nbd_pkg::sum_width(MaxScale);

    logic                         adv;
    logic                         accept;
    logic [ScaleW-1:0]            scale;
    logic [AddrW-1:0]             rd_addr;
    nbd_pkg::pix_ctl_t            op;
    logic [AddrW-1:0]             op_addr;
    logic [nbd_pkg::PIXEL_W-1:0]  op_pixel;
    logic [SumW-1:0]              acc_sum;
    nbd_pkg::res_ctl_t            acc_ctl;
    logic [nbd_pkg::VALUE_W-1:0]  div_value;
    nbd_pkg::res_ctl_t            div_ctl;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [nbd_pkg::VALUE_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                         m_tlast_reg, m_tlast_next;

    // whole pipeline moves whenever the output slot is free or being emptied
    assign adv    = !m_tvalid_reg || m_tready;
    assign accept = s_tvalid && adv;

    nbd_seq #(
        .MaxWidth (MaxWidth),
        .MaxScale (MaxScale)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .adv        (adv),
        .pixel_in   (s_tdata),
        .scale_o    (scale),
        .rd_addr    (rd_addr),
        .op_o       (op),
        .op_addr_o  (op_addr),
        .op_pixel_o (op_pixel)
    );

    nbd_acc #(
        .MaxWidth (MaxWidth),
        .MaxScale (MaxScale)
    ) u_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .rd_en      (accept),
        .rd_addr    (rd_addr),
        .op_i       (op),
        .op_addr_i  (op_addr),
        .op_pixel_i (op_pixel),
        .sum_o      (acc_sum),
        .ctl_o      (acc_ctl)
    );

    nbd_div #(
        .MaxScale (MaxScale)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .scale_i (scale),
        .sum_i   (acc_sum),
        .ctl_i   (acc_ctl),
        .value_o (div_value),
        .ctl_o   (div_ctl)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (adv) begin
            m_tvalid_next = div_ctl.valid;
            m_tdata_next  = div_value;
            m_tlast_next  = div_ctl.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: rtl/nbd_checker.sv
module nbd_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [15:0]                       m_tdata,
    input logic                              m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // input side only waits on a full output slot
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output slot");

    // block averages never exceed 255/128 - 1
    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[15] |-> m_tdata[14:0] <= 15'h7F00)
        else $error("result above the largest average");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

endmodule

bind normalized_box_downsampler nbd_checker u_nbd_checker (.*);

// File: dv/normalized_box_downsampler_test.sv
module normalized_box_downsampler_test;

    localparam logic [nbd_pkg::CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_PIXELS = 1150;
    localparam int CYCLE_LIMIT   = 500000;

    typedef enum int {PACE_FULL, PACE_SLOW_SOURCE, PACE_SLOW_SINK, PACE_BOTH} pace_t;

    typedef struct {
        logic signed [nbd_pkg::VALUE_W-1:0] value;
        logic                               last;
    } block_avg_t;

    function automatic int clamp_dim(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    class box_average_tracker;
        bit [nbd_pkg::SCALE_CFG_W-1:0] scale_reg;
        bit [nbd_pkg::DIM_CFG_W-1:0]   width_reg;
        bit [nbd_pkg::DIM_CFG_W-1:0]   height_reg;
        bit [15:0]            col_sum [nbd_pkg::MAX_WIDTH_DEF];
        bit [8:0]             pix_col, pix_row, blk_col;
        bit [4:0]             sub_col, sub_row;
        block_avg_t           expected_blocks [$];
        int                   err_count;

        function new();
            scale_reg  = 5'(nbd_pkg::SCALE_RST);
            width_reg  = 9'(nbd_pkg::WIDTH_RST);
            height_reg = 9'(nbd_pkg::HEIGHT_RST);
            err_count  = 0;
            restart_image();
        endfunction

        function void restart_image();
            pix_col = '0;
            pix_row = '0;
            blk_col = '0;
            sub_col = '0;
            sub_row = '0;
        endfunction

        function void note_config(logic [nbd_pkg::CFG_ADDR_W-1:0] addr,
                                  logic [nbd_pkg::CFG_DATA_W-1:0] data);
            case (addr)
                nbd_pkg::CFG_SCALE: begin
                    scale_reg = data[nbd_pkg::SCALE_CFG_W-1:0];
                end
                nbd_pkg::CFG_WIDTH: begin
                    width_reg = data;
                end
                nbd_pkg::CFG_HEIGHT: begin
                    height_reg = data;
                end
                default: begin
                    return;
                end
            endcase
            restart_image();
        endfunction

        function void note_pixel(logic [nbd_pkg::PIXEL_W-1:0] pix);
            int s, w, h, blocks_wide, cols_used, rows_used;
            bit [15:0] sum;
            bit [31:0] quot;
            block_avg_t blk;
            s = clamp_dim(scale_reg, nbd_pkg::MAX_SCALE_DEF);
            w = clamp_dim(width_reg, nbd_pkg::MAX_WIDTH_DEF);
            h = clamp_dim(height_reg, nbd_pkg::HEIGHT_LIMIT);
            blocks_wide = w / s;
            cols_used = blocks_wide * s;
            rows_used = (h / s) * s;
            if (pix_col < cols_used && pix_row < rows_used) begin
                // first pixel of a block overwrites the stale column sum
                if (sub_row == 0 && sub_col == 0)
                    sum = 16'(pix);
                else
                    sum = col_sum[blk_col] + 16'(pix);
                col_sum[blk_col] = sum;
                if (sub_row == s - 1 && sub_col == s - 1) begin
                    quot = ({16'd0, sum} << 8) / (s * s);
                    blk.value = quot[15:0] + nbd_pkg::VALUE_OFFSET;
                    blk.last = (blk_col == blocks_wide - 1) && (pix_row == rows_used - 1);
                    expected_blocks = {expected_blocks, blk};
                end
                if (sub_col == s - 1) begin
                    sub_col = '0;
                    blk_col++;
                end else begin
                    sub_col++;
                end
            end
            pix_col++;
            if (pix_col >= w) begin
                pix_col = '0;
                sub_col = '0;
                blk_col = '0;
                pix_row++;
                sub_row = (sub_row >= s - 1) ? 5'd0 : 5'(sub_row + 5'd1);
                if (pix_row >= h) begin
                    pix_row = '0;
                    sub_row = '0;
                end
            end
        endfunction

        task report(string msg);
            err_count++;
            $display("mismatch: %s", msg);
        endtask

        task check_block(logic [nbd_pkg::VALUE_W-1:0] value, logic last);
            block_avg_t blk;
            if (expected_blocks.size() == 0) begin
                report($sformatf("unexpected result value=%0d last=%b", $signed(value), last));
            end else begin
                blk = expected_blocks.pop_front();
                if (value !== blk.value)
                    report($sformatf("value got %0d want %0d", $signed(value), blk.value));
                if (last !== blk.last)
                    report($sformatf("last got %b want %b (value %0d)", last, blk.last,
                                     blk.value));
            end
        endtask
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;   // [7:0] pixel
    logic                           m_tvalid;
    logic                           m_tready;
    logic [15:0]                    m_tdata;   // [15:0] value
    logic                           m_tlast;
    logic                           cfg_we;
    logic [nbd_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [nbd_pkg::CFG_DATA_W-1:0] cfg_wdata;

    box_average_tracker tracker = new();
    int source_idle_pct = 0;
    int sink_stall_pct = 0;
    int cycle_count = 0;

    normalized_box_downsampler uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_block(m_tdata, m_tlast);
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic set_pace(pace_t pace);
        case (pace)
            PACE_FULL: begin
                source_idle_pct = 0;
                sink_stall_pct = 0;
            end
            PACE_SLOW_SOURCE: begin
                source_idle_pct = 78;
                sink_stall_pct = 0;
            end
            PACE_SLOW_SINK: begin
                source_idle_pct = 0;
                sink_stall_pct = 78;
            end
            default: begin
                source_idle_pct = 27;
                sink_stall_pct = 27;
            end
        endcase
    endtask

    // called and returns at a falling edge
    task automatic send_pixel(logic [7:0] pix);
        while ($urandom_range(0, 99) < source_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        do @(posedge aclk); while (!s_tready);
        tracker.note_pixel(pix);
        @(negedge aclk);
    endtask

    // pixels that give no result may still be in flight, so hold off a bit more
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.expected_blocks.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_config(int sc, int w, int h, bit poke_unused);
        logic [nbd_pkg::CFG_ADDR_W-1:0] addrs [4];
        logic [nbd_pkg::CFG_DATA_W-1:0] vals [4];
        int n;
        addrs[0] = nbd_pkg::CFG_SCALE;
        addrs[1] = nbd_pkg::CFG_WIDTH;
        addrs[2] = nbd_pkg::CFG_HEIGHT;
        addrs[3] = CFG_UNUSED;
        // junk in the bits above the scale field
        vals[0] = {4'($urandom_range(0, 15)), 5'(sc)};
        vals[1] = 9'(w);
        vals[2] = 9'(h);
        vals[3] = 9'($urandom_range(0, 511));
        n = poke_unused ? 4 : 3;
        for (int i = 0; i < n; i++) begin
            cfg_we <= 1'b1;
            cfg_addr <= addrs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            tracker.note_config(addrs[i], vals[i]);
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 15))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin : stimulus
        int sc, w, h, n, img, phase, random_sent;
        logic [7:0] band_pix [15];
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = nbd_pkg::CFG_SCALE;
        cfg_wdata = '0;
        aresetn = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: plain normalization of the byte extremes
        set_pace(PACE_FULL);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        send_pixel(8'd127);
        send_pixel(8'd1);
        send_pixel(8'd254);

        // 2x2 blocks on a 5x3 image: right column and bottom row are dropped
        band_pix = '{8'd255, 8'd255, 8'd0, 8'd0, 8'd9,
                     8'd255, 8'd255, 8'd0, 8'd0, 8'd9,
                     8'd7, 8'd7, 8'd7, 8'd7, 8'd7};
        settle();
        write_config(2, 5, 3, 1'b0);
        foreach (band_pix[i])
            send_pixel(band_pix[i]);

        // image smaller than one block
        settle();
        write_config(4, 3, 3, 1'b1);
        repeat (4) send_pixel(pick_pixel());

        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            case (phase)
                0: begin
                    sc = 31; w = 20; h = 16;
                    n = 320 + $urandom_range(0, 5);
                end
                1: begin
                    sc = 1; w = 511; h = 1;
                    n = 256 + $urandom_range(1, 8);
                end
                2: begin
                    sc = 1; w = 1; h = 300;
                    n = 256 + $urandom_range(1, 8);
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0: sc = 0;
                        1: sc = $urandom_range(17, 31);
                        2: sc = 16;
                        3, 4: sc = 1;
                        default: sc = $urandom_range(2, 6);
                    endcase
                    case ($urandom_range(0, 9))
                        0: w = 0;
                        1: w = $urandom_range(257, 511);
                        2: w = 256;
                        default: w = $urandom_range(1, 24);
                    endcase
                    case ($urandom_range(0, 9))
                        0: h = 0;
                        1: h = $urandom_range(257, 511);
                        default: h = $urandom_range(1, 12);
                    endcase
                    img = clamp_dim(w, nbd_pkg::MAX_WIDTH_DEF) *
                          clamp_dim(h, nbd_pkg::HEIGHT_LIMIT);
                    // mostly whole images, sometimes cut short by the next write
                    if ($urandom_range(0, 3) == 0)
                        n = $urandom_range(1, img);
                    else
                        n = img * $urandom_range(1, 2);
                    if (n > 300)
                        n = 300;
                end
            endcase
            settle();
            set_pace(pace_t'(phase % 4));
            write_config(sc, w, h, ($urandom_range(0, 7) == 0));
            repeat (n) send_pixel(pick_pixel());
            random_sent += n;
            phase++;
        end

        settle();
        if (tracker.err_count == 0 && tracker.expected_blocks.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
